FILE: hw/rtl/dctcp_rate_update_assert.svh
// Assertion macros for the rate update block
`ifndef DCTCP_RATE_UPDATE_ASSERT_SVH
`define DCTCP_RATE_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define DRU_ASSERT_IMP(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (c)) else $error("assertion failed");
`define DRU_ASSERT_NXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (c)) else $error("assertion failed");
`else
`define DRU_ASSERT_IMP(lbl, a, c)
`define DRU_ASSERT_NXT(lbl, a, c)
`endif
`endif

FILE: hw/rtl/dru_pkg.sv
// ----------------------------------------------------------------------------
// dru_pkg
// Shared types and constants of the DCTCP rate update block.
// ----------------------------------------------------------------------------
package dru_pkg;
  localparam logic [31:0] FULL32 = 32'hFFFF_FFFF;

  // register indexes
  localparam logic [2:0] REG_INIT_RATE = 3'd0;
  localparam logic [2:0] REG_MIN_RATE  = 3'd1;
  localparam logic [2:0] REG_MIN_ACKS  = 3'd2;
  localparam logic [2:0] REG_ECN_W     = 3'd3;
  localparam logic [2:0] REG_ADD_STEP  = 3'd4;
  localparam logic [2:0] REG_MULT_INC  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SAMP_MUL, ST_SAMP_DIV, ST_MEAS, ST_DECIDE,
    ST_FRAC_DIV, ST_EWMA_MUL, ST_PREV_MUL, ST_EWMA_DIV, ST_CUT_MUL, ST_MI_MUL,
    ST_RATE_DIV, ST_FINISH, ST_OUT
  } state_t;

  // request to the serial multiply/divide unit
  typedef struct packed {
    logic        mul_go;
    logic        div_go;
    logic [63:0] a;
    logic [31:0] b;
    logic [95:0] num;
    logic [63:0] den;
  } mdu_req_t;

  typedef struct packed {
    logic        busy;
    logic [95:0] res;
  } mdu_rsp_t;
endpackage

FILE: hw/rtl/dru_if.sv
// ----------------------------------------------------------------------------
// dru_in_if / dru_out_if
// Valid/ready channels carrying one tick and one result.
// ----------------------------------------------------------------------------
interface dru_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] ack_count;
  logic [31:0] acked_bytes;
  logic [31:0] ecn_bytes;
  logic [31:0] drop_count;
  logic [31:0] interval_us;
  logic        retransmitted;
  modport source (output valid, mode, ack_count, acked_bytes, ecn_bytes, drop_count,
                  interval_us, retransmitted, input ready);
  modport sink (input valid, mode, ack_count, acked_bytes, ecn_bytes, drop_count,
                interval_us, retransmitted, output ready);
endinterface

interface dru_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rate;
  logic        updated;
  logic        in_slow_start;
  logic [31:0] ecn_fraction;
  logic [31:0] measured_rate;
  modport source (output valid, rate, updated, in_slow_start, ecn_fraction, measured_rate,
                  input ready);
  modport sink (input valid, rate, updated, in_slow_start, ecn_fraction, measured_rate,
                output ready);
endinterface

FILE: hw/rtl/dru_mdu.sv
// ----------------------------------------------------------------------------
// dru_mdu
// Bit-serial unit: shift-add multiply (64 x 32) and restoring divide (96 / 64),
// one bit per cycle.
// ----------------------------------------------------------------------------
module dru_mdu (
  input  logic              clk,
  input  logic              rst_n,
  input  dru_pkg::mdu_req_t req,
  output dru_pkg::mdu_rsp_t rsp
);
  logic        busy_r, busy_nxt;
  logic        is_div_r, is_div_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [95:0] acc_r, acc_nxt;     // product or quotient/dividend shifter
  logic [95:0] mc_r, mc_nxt;       // shifted multiplicand
  logic [31:0] mp_r, mp_nxt;       // multiplier bits
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] den_r, den_nxt;
  logic [64:0] rem_sh;
  logic [65:0] diff;

  assign rem_sh = {rem_r[63:0], acc_r[95]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};

  // advance one bit per cycle
  always_comb begin
    busy_nxt = busy_r; is_div_nxt = is_div_r; cnt_nxt = cnt_r; acc_nxt = acc_r;
    mc_nxt = mc_r; mp_nxt = mp_r; rem_nxt = rem_r; den_nxt = den_r;
    if (!busy_r) begin
      if (req.mul_go) begin
        busy_nxt = 1'b1; is_div_nxt = 1'b0; cnt_nxt = 7'd32;
        acc_nxt = '0; mc_nxt = {32'd0, req.a}; mp_nxt = req.b;
      end else if (req.div_go) begin
        busy_nxt = 1'b1; is_div_nxt = 1'b1; cnt_nxt = 7'd96;
        acc_nxt = req.num; rem_nxt = '0; den_nxt = req.den;
      end
    end else begin
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
      if (is_div_r) begin
        if (!diff[65]) begin
          rem_nxt = diff[64:0];
          acc_nxt = {acc_r[94:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          acc_nxt = {acc_r[94:0], 1'b0};
        end
      end else begin
        if (mp_r[0]) acc_nxt = acc_r + mc_r;
        mc_nxt = {mc_r[94:0], 1'b0};
        mp_nxt = {1'b0, mp_r[31:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    is_div_r <= is_div_nxt; acc_r <= acc_nxt; mc_r <= mc_nxt; mp_r <= mp_nxt;
    rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.res  = acc_r;
endmodule

FILE: hw/rtl/dru_regs.sv
// ----------------------------------------------------------------------------
// dru_regs
// APB register file holding the six 32-bit control registers.
// ----------------------------------------------------------------------------
module dru_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [31:0] init_rate,
  output logic [31:0] min_rate,
  output logic [31:0] min_acks,
  output logic [31:0] ecn_weight,
  output logic [31:0] add_step,
  output logic [31:0] mult_increase
);
  logic [31:0] regs_r [6];
  logic [2:0]  idx;
  logic        wr;

  assign idx = cfg_paddr[4:2];
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // write beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) regs_r[i] <= '0;
    end else if (wr && idx < 3'd6) begin
      regs_r[idx] <= cfg_pwdata;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (idx < 3'd6) cfg_prdata = regs_r[idx];
  end

  assign init_rate     = regs_r[dru_pkg::REG_INIT_RATE];
  assign min_rate      = regs_r[dru_pkg::REG_MIN_RATE];
  assign min_acks      = regs_r[dru_pkg::REG_MIN_ACKS];
  assign ecn_weight    = regs_r[dru_pkg::REG_ECN_W];
  assign add_step      = regs_r[dru_pkg::REG_ADD_STEP];
  assign mult_increase = regs_r[dru_pkg::REG_MULT_INC];
endmodule

FILE: hw/rtl/dctcp_rate_update.sv
// ----------------------------------------------------------------------------
// dctcp_rate_update
// Per-flow DCTCP rate controller around a bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
// Flow: a restart or a tick with too few acks goes straight to the result beat;
//   an update steps through sampling, the decision and, as needed, serial multiplies and divides.
// Throughput: one item at a time; the next tick is taken the cycle after the
//   result beat leaves.
// Reset: synchronous active-low rst_n clears flow state and registers.
`include "dctcp_rate_update_assert.svh"
module dctcp_rate_update (
  input  logic        clk,
  input  logic        rst_n,
  dru_in_if.sink      in_ch,
  dru_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [31:0] init_rate, min_rate, min_acks, ecn_weight, add_step, mult_increase;

  dru_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .init_rate, .min_rate, .min_acks, .ecn_weight,
    .add_step, .mult_increase
  );

  dru_pkg::mdu_req_t req;
  dru_pkg::mdu_rsp_t rsp;
  dru_mdu u_mdu (.clk, .rst_n, .req, .rsp);

  dru_pkg::state_t st_r, st_nxt;
  logic        started_r, started_nxt;   // unit launched in current state

  logic [31:0] cur_rate_r, cur_rate_nxt, ecn_avg_r, ecn_avg_nxt, meas_r, meas_nxt;
  logic        ss_r, ss_nxt, upd_r, upd_nxt;
  logic [31:0] p_acks_r, p_acks_nxt, p_bytes_r, p_bytes_nxt, p_ecn_r, p_ecn_nxt;
  logic [31:0] p_drops_r, p_drops_nxt;
  logic        p_retx_r, p_retx_nxt;
  // working copies of one tick
  logic [31:0] bytes_r, bytes_nxt, mark_r, mark_nxt, drops_r, drops_nxt, us_r, us_nxt;
  logic        retx_r, retx_nxt;
  logic [31:0] rate_r, rate_nxt, samp_r, samp_nxt, frac_r, frac_nxt;
  logic [95:0] tmp_r, tmp_nxt;

  logic [31:0] acks_s, bytes_s, mark_s, drops_s;
  logic [32:0] sum33;
  logic [34:0] meas_sum;
  logic [31:0] rate_fl;

  assign acks_s  = p_acks_r + in_ch.ack_count;
  assign bytes_s = p_bytes_r + in_ch.acked_bytes;
  assign mark_s  = p_ecn_r + in_ch.ecn_bytes;
  assign drops_s = p_drops_r + in_ch.drop_count;
  assign meas_sum = {meas_r, 3'b000} - {3'b000, meas_r} + {3'b000, samp_r};
  assign rate_fl  = (rate_r < min_rate) ? min_rate : rate_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      dru_pkg::ST_IDLE: if (in_ch.valid) begin
        if (in_ch.mode || acks_s < min_acks) st_nxt = dru_pkg::ST_OUT;
        else st_nxt = dru_pkg::ST_SAMP_MUL;
      end
      dru_pkg::ST_SAMP_MUL: if (us_r == '0) st_nxt = dru_pkg::ST_MEAS;
        else if (started_r && !rsp.busy) st_nxt = dru_pkg::ST_SAMP_DIV;
      dru_pkg::ST_SAMP_DIV, dru_pkg::ST_FRAC_DIV, dru_pkg::ST_EWMA_DIV,
      dru_pkg::ST_RATE_DIV, dru_pkg::ST_EWMA_MUL, dru_pkg::ST_PREV_MUL,
      dru_pkg::ST_CUT_MUL, dru_pkg::ST_MI_MUL: if (started_r && !rsp.busy) begin
        unique case (st_r)
          dru_pkg::ST_SAMP_DIV: st_nxt = dru_pkg::ST_MEAS;
          dru_pkg::ST_FRAC_DIV: st_nxt = dru_pkg::ST_EWMA_MUL;
          dru_pkg::ST_EWMA_MUL: st_nxt = dru_pkg::ST_PREV_MUL;
          dru_pkg::ST_PREV_MUL: st_nxt = dru_pkg::ST_EWMA_DIV;
          dru_pkg::ST_EWMA_DIV: st_nxt = (mark_r != '0) ? dru_pkg::ST_CUT_MUL :
                                         (mult_increase == '0) ? dru_pkg::ST_FINISH :
                                         dru_pkg::ST_MI_MUL;
          dru_pkg::ST_CUT_MUL, dru_pkg::ST_MI_MUL: st_nxt = dru_pkg::ST_RATE_DIV;
          default: st_nxt = dru_pkg::ST_FINISH;
        endcase
      end
      dru_pkg::ST_MEAS: st_nxt = dru_pkg::ST_DECIDE;
      dru_pkg::ST_DECIDE: begin
        if (ss_r && drops_r == '0 && mark_r == '0 && !retx_r) st_nxt = dru_pkg::ST_FINISH;
        else if (drops_r != '0 || retx_r) st_nxt = dru_pkg::ST_FINISH;
        else if (bytes_r != '0) st_nxt = dru_pkg::ST_FRAC_DIV;
        else if (mark_r != '0) st_nxt = dru_pkg::ST_CUT_MUL;
        else if (mult_increase == '0) st_nxt = dru_pkg::ST_FINISH;
        else st_nxt = dru_pkg::ST_MI_MUL;
      end
      dru_pkg::ST_FINISH: st_nxt = dru_pkg::ST_OUT;
      dru_pkg::ST_OUT: if (out_ch.ready) st_nxt = dru_pkg::ST_IDLE;
      default: st_nxt = dru_pkg::ST_IDLE;
    endcase
  end

  // datapath and unit requests
  always_comb begin
    started_nxt = 1'b0;
    cur_rate_nxt = cur_rate_r; ecn_avg_nxt = ecn_avg_r; meas_nxt = meas_r;
    ss_nxt = ss_r; upd_nxt = upd_r;
    p_acks_nxt = p_acks_r; p_bytes_nxt = p_bytes_r; p_ecn_nxt = p_ecn_r;
    p_drops_nxt = p_drops_r; p_retx_nxt = p_retx_r;
    bytes_nxt = bytes_r; mark_nxt = mark_r; drops_nxt = drops_r; us_nxt = us_r;
    retx_nxt = retx_r; rate_nxt = rate_r; samp_nxt = samp_r; frac_nxt = frac_r;
    tmp_nxt = tmp_r;
    sum33 = '0;
    req = '0;
    unique case (st_r)
      dru_pkg::ST_IDLE: if (in_ch.valid) begin
        upd_nxt = 1'b0;
        if (in_ch.mode) begin
          cur_rate_nxt = init_rate; ss_nxt = 1'b1; ecn_avg_nxt = '0; meas_nxt = '0;
          p_acks_nxt = '0; p_bytes_nxt = '0; p_ecn_nxt = '0; p_drops_nxt = '0;
          p_retx_nxt = 1'b0;
        end else if (acks_s < min_acks) begin
          p_acks_nxt = acks_s; p_bytes_nxt = bytes_s; p_ecn_nxt = mark_s;
          p_drops_nxt = drops_s; p_retx_nxt = p_retx_r | in_ch.retransmitted;
        end else begin
          upd_nxt = 1'b1;
          bytes_nxt = bytes_s; mark_nxt = mark_s; drops_nxt = drops_s;
          us_nxt = in_ch.interval_us; retx_nxt = p_retx_r | in_ch.retransmitted;
          rate_nxt = cur_rate_r; samp_nxt = '0;
          p_acks_nxt = '0; p_bytes_nxt = '0; p_ecn_nxt = '0; p_drops_nxt = '0;
          p_retx_nxt = 1'b0;
        end
      end
      dru_pkg::ST_SAMP_MUL: begin
        req.a = {32'd0, bytes_r}; req.b = 32'd8000;
        req.mul_go = !started_r && us_r != '0; started_nxt = !(started_r && !rsp.busy);
      end
      dru_pkg::ST_SAMP_DIV: begin
        req.num = {32'd0, rsp.res[63:0]}; req.den = {32'd0, us_r};
        req.div_go = !started_r; started_nxt = !(started_r && !rsp.busy);
        if (started_r && !rsp.busy)
          samp_nxt = (rsp.res[95:32] != '0) ? dru_pkg::FULL32 : rsp.res[31:0];
      end
      dru_pkg::ST_MEAS: meas_nxt = meas_sum[34:3];
      dru_pkg::ST_DECIDE: begin
        if (ss_r) begin
          if (drops_r == '0 && mark_r == '0 && !retx_r)
            rate_nxt = rate_r[31] ? dru_pkg::FULL32 : {rate_r[30:0], 1'b0};
          else ss_nxt = 1'b0;
        end
        if (!(ss_r && drops_r == '0 && mark_r == '0 && !retx_r)) begin
          if (drops_r != '0 || retx_r) rate_nxt = {1'b0, rate_r[31:1]};
          else begin
            // clip marks to bytes only when bytes were acked
            if (bytes_r != '0 && mark_r > bytes_r) mark_nxt = bytes_r;
            if (bytes_r == '0 && mark_r == '0) begin
              sum33 = {1'b0, rate_r} + {1'b0, add_step};
              if (mult_increase == '0)
                rate_nxt = sum33[32] ? dru_pkg::FULL32 : sum33[31:0];
            end
          end
        end
      end
      dru_pkg::ST_FRAC_DIV: begin
        req.num = {32'd0, mark_r, 32'd0} - {64'd0, mark_r};
        req.den = {32'd0, bytes_r};
        req.div_go = !started_r; started_nxt = !(started_r && !rsp.busy);
        if (started_r && !rsp.busy) frac_nxt = rsp.res[31:0];
      end
      dru_pkg::ST_EWMA_MUL: begin
        // new fraction times its weight
        req.a = {32'd0, frac_r}; req.b = ecn_weight;
        req.mul_go = !started_r; started_nxt = !(started_r && !rsp.busy);
        if (started_r && !rsp.busy) tmp_nxt = rsp.res;
      end
      dru_pkg::ST_PREV_MUL: begin
        // add the previous average times the remaining weight
        req.a = {32'd0, ecn_avg_r}; req.b = dru_pkg::FULL32 - ecn_weight;
        req.mul_go = !started_r; started_nxt = !(started_r && !rsp.busy);
        if (started_r && !rsp.busy) tmp_nxt = {32'd0, tmp_r[63:0] + rsp.res[63:0]};
      end
      dru_pkg::ST_EWMA_DIV: begin
        // scale the weighted sum back by 2^32-1
        req.num = tmp_r; req.den = {32'd0, dru_pkg::FULL32};
        req.div_go = !started_r; started_nxt = !(started_r && !rsp.busy);
        if (started_r && !rsp.busy) begin
          ecn_avg_nxt = rsp.res[31:0];
          sum33 = {1'b0, rate_r} + {1'b0, add_step};
          if (mark_r == '0 && mult_increase == '0)
            rate_nxt = sum33[32] ? dru_pkg::FULL32 : sum33[31:0];
        end
      end
      dru_pkg::ST_CUT_MUL: begin
        req.a = {32'd0, rate_r}; req.b = dru_pkg::FULL32 - {1'b0, ecn_avg_r[31:1]};
        req.mul_go = !started_r; started_nxt = !(started_r && !rsp.busy);
        if (started_r && !rsp.busy) tmp_nxt = rsp.res;
      end
      dru_pkg::ST_MI_MUL: begin
        req.a = {32'd0, rate_r}; req.b = mult_increase;
        req.mul_go = !started_r; started_nxt = !(started_r && !rsp.busy);
        if (started_r && !rsp.busy) tmp_nxt = rsp.res;
      end
      dru_pkg::ST_RATE_DIV: begin
        req.num = tmp_r; req.den = {32'd0, dru_pkg::FULL32};
        req.div_go = !started_r; started_nxt = !(started_r && !rsp.busy);
        if (started_r && !rsp.busy) begin
          if (mark_r != '0) rate_nxt = rsp.res[31:0];
          else begin
            sum33 = {1'b0, rate_r} + {1'b0, rsp.res[31:0]};
            rate_nxt = (rsp.res[95:32] != '0 || sum33[32]) ? dru_pkg::FULL32 : sum33[31:0];
          end
        end
      end
      dru_pkg::ST_FINISH: cur_rate_nxt = rate_fl;
      dru_pkg::ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dru_pkg::ST_IDLE; started_r <= 1'b0;
      cur_rate_r <= '0; ecn_avg_r <= '0; meas_r <= '0; ss_r <= 1'b0; upd_r <= 1'b0;
      p_acks_r <= '0; p_bytes_r <= '0; p_ecn_r <= '0; p_drops_r <= '0; p_retx_r <= 1'b0;
    end else begin
      st_r <= st_nxt; started_r <= started_nxt;
      cur_rate_r <= cur_rate_nxt; ecn_avg_r <= ecn_avg_nxt; meas_r <= meas_nxt;
      ss_r <= ss_nxt; upd_r <= upd_nxt;
      p_acks_r <= p_acks_nxt; p_bytes_r <= p_bytes_nxt; p_ecn_r <= p_ecn_nxt;
      p_drops_r <= p_drops_nxt; p_retx_r <= p_retx_nxt;
    end
    bytes_r <= bytes_nxt; mark_r <= mark_nxt; drops_r <= drops_nxt; us_r <= us_nxt;
    retx_r <= retx_nxt; rate_r <= rate_nxt; samp_r <= samp_nxt; frac_r <= frac_nxt;
    tmp_r <= tmp_nxt;
  end

  assign in_ch.ready          = (st_r == dru_pkg::ST_IDLE);
  assign out_ch.valid         = (st_r == dru_pkg::ST_OUT);
  assign out_ch.rate          = cur_rate_r;
  assign out_ch.updated       = upd_r;
  assign out_ch.in_slow_start = ss_r;
  assign out_ch.ecn_fraction  = ecn_avg_r;
  assign out_ch.measured_rate = meas_r;

  `DRU_ASSERT_IMP(a_excl, out_ch.valid, !in_ch.ready)
  `DRU_ASSERT_NXT(a_restart, in_ch.valid && in_ch.ready && in_ch.mode, out_ch.valid && !out_ch.updated)
  `DRU_ASSERT_NXT(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.rate))
endmodule

FILE: sim/dctcp_rate_update_tb.sv
// ----------------------------------------------------------------------------
// dctcp_rate_update_tb
// Drives control ticks and restarts into the rate update block, predicts each
// result beat with an independent model of the DCTCP rate controller and
// compares every field. Registers are reprogrammed between phases.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [31:0] rate;
  logic        updated;
  logic        in_slow_start;
  logic [31:0] ecn_fraction;
  logic [31:0] measured_rate;
} rate_result_t;

class rate_scoreboard;
  bit [31:0] init_rate, min_rate, min_acks, ecn_weight, add_step, mult_inc;
  bit [31:0] cur_rate, ecn_avg, meas_avg;
  bit [31:0] pend_acks, pend_bytes, pend_ecn, pend_drops;
  bit        slow_start, pend_retx;
  rate_result_t pending_q[$];
  int errors;

  function void clear_flow();
    cur_rate = 0; slow_start = 0; ecn_avg = 0; meas_avg = 0;
    pend_acks = 0; pend_bytes = 0; pend_ecn = 0; pend_drops = 0; pend_retx = 0;
  endfunction

  function void set_reg(bit [2:0] idx, bit [31:0] v);
    case (idx)
      dru_pkg::REG_INIT_RATE: init_rate = v;
      dru_pkg::REG_MIN_RATE:  min_rate = v;
      dru_pkg::REG_MIN_ACKS:  min_acks = v;
      dru_pkg::REG_ECN_W:     ecn_weight = v;
      dru_pkg::REG_ADD_STEP:  add_step = v;
      dru_pkg::REG_MULT_INC:  mult_inc = v;
      default: ;
    endcase
  endfunction

  // Predict the result of one accepted tick
  function void note_tick(bit mode, bit [31:0] ack, bit [31:0] byt, bit [31:0] ecn,
                          bit [31:0] drp, bit [31:0] us, bit retx_in);
    bit [31:0] acks, bytes, marked, drops, rate;
    bit [63:0] samp, frac, inc;
    bit [127:0] wide;
    bit retx, upd;
    rate_result_t r;
    upd = 0;
    if (mode) begin
      clear_flow();
      cur_rate = init_rate;
      slow_start = 1;
    end else begin
      acks = pend_acks + ack; bytes = pend_bytes + byt;
      marked = pend_ecn + ecn; drops = pend_drops + drp;
      retx = pend_retx | retx_in;
      if (acks < min_acks) begin
        pend_acks = acks; pend_bytes = bytes; pend_ecn = marked;
        pend_drops = drops; pend_retx = retx;
      end else begin
        upd = 1;
        rate = cur_rate;
        pend_acks = 0; pend_bytes = 0; pend_ecn = 0; pend_drops = 0; pend_retx = 0;
        // smooth the throughput sample
        if (us == 0) samp = 0;
        else begin
          samp = (64'(bytes) * 64'd8000) / 64'(us);
          if (samp > 64'hFFFF_FFFF) samp = 64'hFFFF_FFFF;
        end
        meas_avg = 32'((64'd7 * 64'(meas_avg) + samp) / 64'd8);
        if (slow_start) begin
          if (drops == 0 && marked == 0 && !retx)
            rate = (64'(rate) * 2 <= 64'hFFFF_FFFF) ? rate * 2 : 32'hFFFF_FFFF;
          else slow_start = 0;
        end
        if (!slow_start) begin
          if (drops > 0 || retx) rate = rate / 2;
          else begin
            if (bytes > 0) begin
              if (marked > bytes) marked = bytes;
              frac = (64'(marked) * 64'hFFFF_FFFF) / 64'(bytes);
              wide = 128'(frac) * 128'(ecn_weight) +
                     128'(ecn_avg) * (128'hFFFF_FFFF - 128'(ecn_weight));
              ecn_avg = 32'(wide / 128'hFFFF_FFFF);
            end
            if (marked > 0)
              rate = 32'((64'(rate) * (64'hFFFF_FFFF - 64'(ecn_avg / 2))) / 64'hFFFF_FFFF);
            else if (mult_inc == 0) begin
              if (32'hFFFF_FFFF - rate < add_step) rate = 32'hFFFF_FFFF;
              else rate += add_step;
            end else begin
              inc = (64'(rate) * 64'(mult_inc)) / 64'hFFFF_FFFF;
              if (inc > 64'(32'hFFFF_FFFF - rate)) rate = 32'hFFFF_FFFF;
              else rate += 32'(inc);
            end
          end
        end
        if (rate < min_rate) rate = min_rate;
        cur_rate = rate;
      end
    end
    r.rate = cur_rate; r.updated = upd; r.in_slow_start = slow_start;
    r.ecn_fraction = ecn_avg; r.measured_rate = meas_avg;
    pending_q.push_back(r);
  endfunction

  // Compare one result beat with the oldest prediction
  function void check_result(rate_result_t got);
    rate_result_t exp_r;
    if (pending_q.size() == 0) begin
      $error("unexpected result beat rate=%0h", got.rate);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.rate !== exp_r.rate) begin
      $error("rate exp %0h got %0h", exp_r.rate, got.rate); errors++;
    end
    if (got.updated !== exp_r.updated) begin
      $error("updated exp %0h got %0h", exp_r.updated, got.updated); errors++;
    end
    if (got.in_slow_start !== exp_r.in_slow_start) begin
      $error("in_slow_start exp %0h got %0h", exp_r.in_slow_start, got.in_slow_start);
      errors++;
    end
    if (got.ecn_fraction !== exp_r.ecn_fraction) begin
      $error("ecn_fraction exp %0h got %0h", exp_r.ecn_fraction, got.ecn_fraction);
      errors++;
    end
    if (got.measured_rate !== exp_r.measured_rate) begin
      $error("measured_rate exp %0h got %0h", exp_r.measured_rate, got.measured_rate);
      errors++;
    end
  endfunction
endclass

module dctcp_rate_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  dru_in_if  in_ch();
  dru_out_if out_ch();

  dctcp_rate_update dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  rate_scoreboard sb = new();
  int idle_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Count cycles without any beat and end a hung run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Accept result beats with random stalls and check them
  initial begin
    int gap;
    rate_result_t got;
    out_ch.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk iff out_ch.valid);
      got.rate = out_ch.rate; got.updated = out_ch.updated;
      got.in_slow_start = out_ch.in_slow_start;
      got.ecn_fraction = out_ch.ecn_fraction; got.measured_rate = out_ch.measured_rate;
      sb.check_result(got);
    end
  end

  task automatic write_reg(bit [2:0] idx, bit [31:0] v);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= 5'(idx) << 2; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk iff cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Hold until every prediction is matched, then let the block settle
  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send_tick(bit mode, bit [31:0] ack, bit [31:0] byt, bit [31:0] ecn,
                           bit [31:0] drp, bit [31:0] us, bit retx, bit nogap = 0);
    int gap;
    gap = (nogap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.mode <= mode; in_ch.ack_count <= ack;
    in_ch.acked_bytes <= byt; in_ch.ecn_bytes <= ecn; in_ch.drop_count <= drp;
    in_ch.interval_us <= us; in_ch.retransmitted <= retx;
    @(posedge clk iff in_ch.ready);
    sb.note_tick(mode, ack, byt, ecn, drp, us, retx);
  endtask

  function automatic bit [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 16);
      3: return $urandom_range(0, 100000);
      default: return $urandom();
    endcase
  endfunction

  task automatic program_all(bit [31:0] ir, bit [31:0] mr, bit [31:0] ma,
                             bit [31:0] ew, bit [31:0] as, bit [31:0] mi);
    write_reg(dru_pkg::REG_INIT_RATE, ir);
    write_reg(dru_pkg::REG_MIN_RATE, mr);
    write_reg(dru_pkg::REG_MIN_ACKS, ma);
    write_reg(dru_pkg::REG_ECN_W, ew);
    write_reg(dru_pkg::REG_ADD_STEP, as);
    write_reg(dru_pkg::REG_MULT_INC, mi);
  endtask

  // Random phase: mostly clean ticks after a restart, some loss, marks and noise
  task automatic random_phase(int n);
    bit [31:0] byt, ecn, drp;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0)
        send_tick(1, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom_range(0, 1));
      else begin
        byt = ($urandom_range(0, 1)) ? $urandom_range(0, 2000000) : rand_word();
        ecn = ($urandom_range(0, 2) == 0) ? rand_word() : 0;
        if (ecn != 0 && $urandom_range(0, 1)) ecn = byt / ($urandom_range(1, 10));
        drp = ($urandom_range(0, 5) == 0) ? rand_word() : 0;
        send_tick(0, ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(0, 20),
                  byt, ecn, drp, ($urandom_range(0, 7) == 0) ? rand_word()
                  : $urandom_range(1, 500), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  initial begin
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    in_ch.valid = 0; in_ch.mode = 0; in_ch.ack_count = 0; in_ch.acked_bytes = 0;
    in_ch.ecn_bytes = 0; in_ch.drop_count = 0; in_ch.interval_us = 0;
    in_ch.retransmitted = 0;
    rst_n = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: restart, slow start, loss, marks, clipping, extremes
    program_all(32'd1000, 32'd10, 32'd2, 32'h4000_0000, 32'd50, 32'd0);
    send_tick(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_tick(1, 0, 0, 0, 0, 0, 0);
    send_tick(0, 1, 1000, 0, 0, 10, 0);            // too few acks
    send_tick(0, 1, 1000, 0, 0, 0, 0);             // doubling, zero elapsed
    send_tick(0, 2, 32'hFFFF_FFFF, 0, 0, 1, 0);    // saturated sample
    send_tick(0, 2, 500, 0, 1, 100, 0);            // loss ends slow start
    send_tick(0, 2, 500, 0, 0, 100, 1);            // retransmit halves
    send_tick(0, 2, 500, 900, 0, 100, 0);          // marks clipped to bytes
    send_tick(0, 2, 0, 0, 0, 100, 0);              // zero bytes, no EWMA
    send_tick(0, 2, 0, 5, 0, 100, 0);              // marks without bytes
    send_tick(0, 2, 800, 0, 0, 100, 0);            // additive increase
    send_tick(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1);
    drain();
    program_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(1, 0, 0, 0, 0, 0, 0);
    send_tick(0, 32'hFFFF_FFFF, 100, 0, 0, 5, 0);  // doubling saturates
    send_tick(0, 32'hFFFF_FFFF, 100, 50, 0, 5, 0);
    send_tick(0, 32'hFFFF_FFFF, 100, 0, 0, 5, 0);  // multiplicative saturates
    drain();
    program_all(32'd7, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_tick(1, 0, 0, 0, 0, 0, 0);
    send_tick(0, 0, 10, 1, 0, 3, 0);
    send_tick(0, 0, 10, 0, 0, 3, 0);
    send_tick(0, 0, 10, 0, 0, 3, 0);

    // Random phases under several settings
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      program_all(rand_word(), ($urandom_range(0, 2) == 0) ? rand_word() : 0,
                  $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(0, 30),
                  $urandom(), rand_word(), ($urandom_range(0, 1)) ? 0 : $urandom());
      send_tick(1, 0, 0, 0, 0, 0, 0);
      random_phase(95);
    end

    drain();
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
